>>> rtl/int_vec3_alu_unit_defines.svh
// ----------------------------------------------------------------------------
// int_vec3_alu_unit_defines : assertion macros
// Concurrent check wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INT_VEC3_ALU_UNIT_DEFINES_SVH
`define INT_VEC3_ALU_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define IVA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("int_vec3_alu_unit: check failed");
`define IVA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("int_vec3_alu_unit: check failed");
`else
`define IVA_ASSERT(lbl, prop)
`define IVA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/iva_pkg.sv
// ----------------------------------------------------------------------------
// iva_pkg : shared definitions of the vector ALU
// Lane width, opcodes, pipeline depth and the records passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package iva_pkg;

   localparam int LANE_W    = 32;
   localparam int OP_W      = 4;
   localparam int DIV_STEPS = LANE_W;
   localparam int LATENCY   = DIV_STEPS + 2;

   localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
   localparam logic [OP_W-1:0] OP_SADD  = 4'd4;
   localparam logic [OP_W-1:0] OP_SSUB  = 4'd5;
   localparam logic [OP_W-1:0] OP_SMUL  = 4'd6;
   localparam logic [OP_W-1:0] OP_SDIV  = 4'd7;
   localparam logic [OP_W-1:0] OP_EQ    = 4'd8;
   localparam logic [OP_W-1:0] OP_NE    = 4'd9;
   localparam logic [OP_W-1:0] OP_DOT   = 4'd10;
   localparam logic [OP_W-1:0] OP_CROSS = 4'd11;

   typedef logic [LANE_W-1:0] word_type;

   typedef struct packed {
      logic            valid;
      logic [OP_W-1:0] op;
      logic            eq;
   } ctl_type;

   typedef struct packed {
      word_type res;
      word_type prod;
      logic     dz;
   } lane_out_type;

endpackage
`default_nettype wire

>>> rtl/iva_lane.sv
// ----------------------------------------------------------------------------
// iva_lane : one vector lane
// Add, subtract, multiply, cross term and a bit-per-stage pipelined divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iva_lane import iva_pkg::*; (
   input  wire logic            clock,
   input  wire logic [OP_W-1:0] op,
   input  wire word_type        a_own,
   input  wire word_type        b_own,
   input  wire word_type        scalar,
   input  wire word_type        a_nxt,
   input  wire word_type        a_prv,
   input  wire word_type        b_nxt,
   input  wire word_type        b_prv,
   output lane_out_type         lane_out
);

   word_type        y_op, m1a, m1b, arith_in, num_abs, den_abs, res_pre;
   logic            is_cross, is_div_in;
   word_type        arith_ff, p1_ff, p2_ff;
   logic [OP_W-1:0] op_ff;
   word_type        rem_ff [0:DIV_STEPS];
   word_type        quo_ff [0:DIV_STEPS];
   word_type        den_ff [0:DIV_STEPS];
   logic            neg_ff [0:DIV_STEPS];
   logic            dzr_ff [0:DIV_STEPS];
   logic            div_ff [0:DIV_STEPS];
   word_type        res_ff [1:DIV_STEPS];
   word_type        prod_ff[1:DIV_STEPS];
   word_type        q_fin;

   assign y_op      = op[2] ? scalar : b_own;
   assign is_cross  = (op == OP_CROSS);
   assign is_div_in = (op == OP_DIV) || (op == OP_SDIV);
   assign m1a       = is_cross ? a_nxt : a_own;
   assign m1b       = is_cross ? b_prv : y_op;
   assign arith_in  = op[0] ? (a_own - y_op) : (a_own + y_op);
   assign num_abs   = a_own[LANE_W-1] ? (~a_own + 1'b1) : a_own;
   assign den_abs   = y_op[LANE_W-1] ? (~y_op + 1'b1) : y_op;

   always_ff @(posedge clock) begin
      op_ff     <= op;
      arith_ff  <= arith_in;
      p1_ff     <= m1a * m1b;
      p2_ff     <= a_prv * b_nxt;
      rem_ff[0] <= '0;
      quo_ff[0] <= num_abs;
      den_ff[0] <= den_abs;
      neg_ff[0] <= a_own[LANE_W-1] ^ y_op[LANE_W-1];
      dzr_ff[0] <= (y_op == '0);
      div_ff[0] <= is_div_in;
   end

   always_comb begin
      case (op_ff)
         OP_ADD, OP_SUB, OP_SADD, OP_SSUB: res_pre = arith_ff;
         OP_MUL, OP_SMUL:                  res_pre = p1_ff;
         OP_CROSS:                         res_pre = p1_ff - p2_ff;
         default:                          res_pre = '0;
      endcase
   end

   // restoring divider, one quotient bit per stage
   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_step
         word_type rem_sh;
         logic     ge;
         assign rem_sh = {rem_ff[k][LANE_W-2:0], quo_ff[k][LANE_W-1]};
         assign ge     = (rem_sh >= den_ff[k]);
         always_ff @(posedge clock) begin
            rem_ff[k+1] <= ge ? (rem_sh - den_ff[k]) : rem_sh;
            quo_ff[k+1] <= {quo_ff[k][LANE_W-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            dzr_ff[k+1] <= dzr_ff[k];
            div_ff[k+1] <= div_ff[k];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      res_ff[1]  <= res_pre;
      prod_ff[1] <= p1_ff;
      for (int i = 2; i <= DIV_STEPS; i++) begin
         res_ff[i]  <= res_ff[i-1];
         prod_ff[i] <= prod_ff[i-1];
      end
   end

   assign q_fin = neg_ff[DIV_STEPS] ? (~quo_ff[DIV_STEPS] + 1'b1) : quo_ff[DIV_STEPS];

   always_comb begin
      lane_out.prod = prod_ff[DIV_STEPS];
      lane_out.dz   = div_ff[DIV_STEPS] & dzr_ff[DIV_STEPS];
      if (div_ff[DIV_STEPS]) begin
         lane_out.res = dzr_ff[DIV_STEPS] ? '0 : q_fin;
      end else begin
         lane_out.res = res_ff[DIV_STEPS];
      end
   end

endmodule
`default_nettype wire

>>> rtl/iva_merge.sv
// ----------------------------------------------------------------------------
// iva_merge : result merge
// Combine the three lanes into the result item and register it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module iva_merge import iva_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctl_type      ctl,
   input  wire lane_out_type lx,
   input  wire lane_out_type ly,
   input  wire lane_out_type lz,
   output logic              strobe,
   output word_type          r_x,
   output word_type          r_y,
   output word_type          r_z,
   output logic              truth,
   output logic              div_zero
);

   logic     strobe_ff;
   word_type rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   logic     truth_ff, dz_ff, truth_in, dz_in;

   always_comb begin
      rx_in    = '0;
      ry_in    = '0;
      rz_in    = '0;
      truth_in = 1'b0;
      dz_in    = 1'b0;
      case (ctl.op)
         OP_ADD, OP_SUB, OP_MUL, OP_SADD, OP_SSUB, OP_SMUL, OP_CROSS: begin
            rx_in = lx.res;
            ry_in = ly.res;
            rz_in = lz.res;
         end
         OP_DIV, OP_SDIV: begin
            rx_in = lx.res;
            ry_in = ly.res;
            rz_in = lz.res;
            dz_in = lx.dz | ly.dz | lz.dz;
         end
         OP_EQ:   truth_in = ctl.eq;
         OP_NE:   truth_in = ~ctl.eq;
         OP_DOT:  rx_in = lx.prod + ly.prod + lz.prod;
         default: rx_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl.valid;
      end
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      rz_ff    <= rz_in;
      truth_ff <= truth_in;
      dz_ff    <= dz_in;
   end

   assign strobe   = strobe_ff;
   assign r_x      = rx_ff;
   assign r_y      = ry_ff;
   assign r_z      = rz_ff;
   assign truth    = truth_ff;
   assign div_zero = dz_ff;

endmodule
`default_nettype wire

>>> rtl/int_vec3_alu_unit.sv
// ----------------------------------------------------------------------------
// int_vec3_alu_unit : three-lane signed integer vector ALU
// Lane-wise arithmetic, compare, dot and cross product on vectors of three 32-bit elements.
//
//   channel   ports        handshake
//   request   req_*        start high, busy low
//   response  rsp_*        rsp_strobe, one cycle, no back-pressure
//
// One item is taken every cycle; busy stays low.
// Every result passes the input registers, the 32-stage lane divider that all
// operations travel alongside, and the merge output register.
// Reset clears the valid bits of the pipeline; items in flight are dropped.
// The response side cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "int_vec3_alu_unit_defines.svh"
module int_vec3_alu_unit import iva_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   output logic                 busy,
   input  wire logic [OP_W-1:0] req_op,
   input  wire word_type        req_a_x,
   input  wire word_type        req_a_y,
   input  wire word_type        req_a_z,
   input  wire word_type        req_b_x,
   input  wire word_type        req_b_y,
   input  wire word_type        req_b_z,
   input  wire word_type        req_scalar,
   output logic                 rsp_strobe,
   output word_type             rsp_r_x,
   output word_type             rsp_r_y,
   output word_type             rsp_r_z,
   output logic                 rsp_truth,
   output logic                 rsp_div_zero
);

   logic            valid_ff;
   logic [OP_W-1:0] op_ff;
   word_type        ax_ff, ay_ff, az_ff, bx_ff, by_ff, bz_ff, s_ff;
   ctl_type         ctl_ff [0:DIV_STEPS];
   lane_out_type    lo_x, lo_y, lo_z;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
      op_ff <= req_op;
      ax_ff <= req_a_x;
      ay_ff <= req_a_y;
      az_ff <= req_a_z;
      bx_ff <= req_b_x;
      by_ff <= req_b_y;
      bz_ff <= req_b_z;
      s_ff  <= req_scalar;
   end

   // advance the control word beside the lane pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STEPS; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0].valid <= valid_ff;
         ctl_ff[0].op    <= op_ff;
         ctl_ff[0].eq    <= (ax_ff == bx_ff) && (ay_ff == by_ff) && (az_ff == bz_ff);
         for (int i = 1; i <= DIV_STEPS; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   iva_lane u_lane_x (
      .clock(clock), .op(op_ff), .a_own(ax_ff), .b_own(bx_ff), .scalar(s_ff),
      .a_nxt(ay_ff), .a_prv(az_ff), .b_nxt(by_ff), .b_prv(bz_ff), .lane_out(lo_x)
   );

   iva_lane u_lane_y (
      .clock(clock), .op(op_ff), .a_own(ay_ff), .b_own(by_ff), .scalar(s_ff),
      .a_nxt(az_ff), .a_prv(ax_ff), .b_nxt(bz_ff), .b_prv(bx_ff), .lane_out(lo_y)
   );

   iva_lane u_lane_z (
      .clock(clock), .op(op_ff), .a_own(az_ff), .b_own(bz_ff), .scalar(s_ff),
      .a_nxt(ax_ff), .a_prv(ay_ff), .b_nxt(bx_ff), .b_prv(by_ff), .lane_out(lo_z)
   );

   iva_merge u_merge (
      .clock(clock), .reset(reset), .ctl(ctl_ff[DIV_STEPS]),
      .lx(lo_x), .ly(lo_y), .lz(lo_z),
      .strobe(rsp_strobe), .r_x(rsp_r_x), .r_y(rsp_r_y), .r_z(rsp_r_z),
      .truth(rsp_truth), .div_zero(rsp_div_zero)
   );

   `IVA_ASSERT(a_latency, (start |-> ##(LATENCY + 1) rsp_strobe))
   `IVA_ASSERT(a_flag_excl, (rsp_strobe |-> !(rsp_truth && rsp_div_zero)))
   `IVA_ASSERT_NEXT(a_no_spurious, !ctl_ff[DIV_STEPS].valid, !rsp_strobe)
   `IVA_ASSERT(a_cmp_zero, (rsp_truth |-> (rsp_r_x == '0 && rsp_r_y == '0 && rsp_r_z == '0)))

endmodule
`default_nettype wire
